FILE: hw/rtl/rhh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV/HSL package
// Shared widths, constants and the item type passed from front to back.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int ChanW    = 8;
    localparam int HueFrac  = 8;
    localparam int SatBits  = 16;
    localparam int HueW     = 11;
    localparam int SatW     = 16;
    localparam int LevelW   = 9;
    // Quotient bits produced by the divider; both quotients stay below 2^QuoW.
    localparam int QuoW     = SatBits + 1;
    localparam int NumW     = QuoW + ChanW;
    localparam int QDepth   = 4;
    localparam int QPtrW    = 2;

    localparam logic [0:0] ModeHsv = 1'b0;
    localparam logic [0:0] ModeHsl = 1'b1;

    // One classified pixel: hue numerator in sixths scaled by delta, the two
    // divisors, the saturation numerator and the level.
    typedef struct packed {
        logic [HueW-1:0]   hue_num;
        logic [ChanW-1:0]  delta;
        logic [ChanW-1:0]  sat_den;
        logic              grey;
        logic [LevelW-1:0] level;
    } item_t;

endpackage

FILE: hw/rtl/rhh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV/HSL front end
// Accepts pixels, finds min/max and sector, and registers one classified item.
// ----------------------------------------------------------------------------
module rhh_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          mode,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rhh_pkg::ChanW-1:0]     red,
    input  logic [rhh_pkg::ChanW-1:0]     green,
    input  logic [rhh_pkg::ChanW-1:0]     blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rhh_pkg::item_t                out_item
);

    logic           fv_reg;
    rhh_pkg::item_t item_reg;
    rhh_pkg::item_t item_next;
    logic [7:0]     mn;
    logic [7:0]     mx;
    logic [7:0]     d;
    logic [8:0]     sum;
    logic signed [11:0] t;
    logic signed [11:0] d12;

    // Min, max and hue numerator; ties for max prefer red, then green.
    always_comb begin
        mn = (red <= green) ? red : green;
        if (blue < mn) begin
            mn = blue;
        end
        mx = (red <= green) ? green : red;
        if (mx < blue) begin
            mx = blue;
        end
        d   = mx - mn;
        d12 = $signed({4'd0, d});
        sum = {1'b0, mx} + {1'b0, mn};
        if (mx == red) begin
            t = $signed({4'd0, green}) - $signed({4'd0, blue});
        end else if (mx == green) begin
            t = $signed({4'd0, blue}) - $signed({4'd0, red}) + (d12 <<< 1);
        end else begin
            t = $signed({4'd0, red}) - $signed({4'd0, green}) + (d12 <<< 2);
        end
        if (t < 0) begin
            t = t + (d12 <<< 2) + (d12 <<< 1);
        end
        item_next.hue_num = t[rhh_pkg::HueW-1:0];
        item_next.delta   = d;
        item_next.grey    = (d == 8'd0);
        if (mode == rhh_pkg::ModeHsv) begin
            item_next.sat_den = mx;
            item_next.level   = {1'b0, mx};
        end else begin
            item_next.sat_den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
            item_next.level   = sum;
        end
    end

    assign in_ready  = !fv_reg || out_ready;
    assign out_valid = fv_reg;
    assign out_item  = item_reg;

    // Holding register toward the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (in_ready) begin
            fv_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hw/rtl/rhh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV/HSL item queue
// Short register queue that decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module rhh_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rhh_pkg::item_t push_item,
    output logic           not_full,
    input  logic           pop,
    output logic           not_empty,
    output rhh_pkg::item_t pop_item
);

    rhh_pkg::item_t               mem_reg [rhh_pkg::QDepth];
    logic [rhh_pkg::QPtrW-1:0]    wptr_reg;
    logic [rhh_pkg::QPtrW-1:0]    rptr_reg;
    logic [rhh_pkg::QPtrW:0]      cnt_reg;

    assign not_full  = (cnt_reg != 3'(rhh_pkg::QDepth));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = mem_reg[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        if (push) begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/rhh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV/HSL divider
// Pipelined restoring divider, one quotient bit per stage, holds while enable is low.
// ----------------------------------------------------------------------------
module rhh_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [rhh_pkg::NumW-1:0]   num,
    input  logic [rhh_pkg::ChanW-1:0]  den,
    output logic [rhh_pkg::QuoW-1:0]   quo
);

    localparam int Q = rhh_pkg::QuoW;
    localparam int C = rhh_pkg::ChanW;

    logic [C-1:0] rem_reg [Q];
    logic [Q-1:0] rest_reg [Q];
    logic [Q-1:0] q_reg [Q];
    logic [C-1:0] den_reg [Q];

    // The top bits of the numerator are below the divisor by construction.
    for (genvar s = 0; s < Q; s++) begin : g_stage
        logic [C-1:0] rem_in;
        logic [Q-1:0] rest_in;
        logic [Q-1:0] q_in;
        logic [C-1:0] den_in;
        logic [C:0]   trial;
        logic         ge;
        if (s == 0) begin : g_first
            assign rem_in  = num[rhh_pkg::NumW-1:Q];
            assign rest_in = num[Q-1:0];
            assign q_in    = '0;
            assign den_in  = den;
        end else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign rest_in = rest_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign den_in  = den_reg[s-1];
        end
        assign trial = {rem_in, rest_in[Q-1]};
        assign ge    = (trial >= {1'b0, den_in});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= ge ? C'(trial - {1'b0, den_in}) : trial[C-1:0];
                rest_reg[s] <= {rest_in[Q-2:0], 1'b0};
                q_reg[s]    <= {q_in[Q-2:0], ge};
                den_reg[s]  <= den_in;
            end
        end
    end

    assign quo = q_reg[Q-1];

endmodule

FILE: hw/rtl/rhh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV/HSL back end
// Two divider pipelines for hue and saturation, then the output register.
// ----------------------------------------------------------------------------
module rhh_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rhh_pkg::item_t                in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rhh_pkg::HueW-1:0]      hue,
    output logic [rhh_pkg::SatW-1:0]      saturation,
    output logic [rhh_pkg::LevelW-1:0]    level
);

    localparam int Q = rhh_pkg::QuoW;

    logic                         en;
    logic                         take;
    logic [Q-1:0]                 v_reg;
    logic [Q-1:0]                 grey_reg;
    logic [rhh_pkg::LevelW-1:0]   lvl_reg [Q];
    logic [rhh_pkg::NumW-1:0]     hnum;
    logic [rhh_pkg::NumW-1:0]     snum;
    logic [rhh_pkg::ChanW-1:0]    hden;
    logic [rhh_pkg::ChanW-1:0]    sden;
    logic [Q-1:0]                 hq;
    logic [Q-1:0]                 sq;
    logic                         ov_reg;
    logic [rhh_pkg::HueW-1:0]     hue_reg;
    logic [rhh_pkg::SatW-1:0]     sat_reg;
    logic [rhh_pkg::LevelW-1:0]   lev_reg;

    // The whole back pipeline moves whenever the output register is free.
    assign en       = !ov_reg || out_ready;
    assign in_ready = en;
    assign take     = en && in_valid;

    // Grey pixels divide by one so the datapath stays defined.
    assign hden = in_item.grey ? 8'd1 : in_item.delta;
    assign sden = in_item.grey ? 8'd1 : in_item.sat_den;
    assign hnum = rhh_pkg::NumW'({in_item.hue_num, 8'd0});
    assign snum = rhh_pkg::NumW'({in_item.delta, 16'd0});

    rhh_div u_hue_div (.aclk(aclk), .en(en), .num(hnum), .den(hden), .quo(hq));
    rhh_div u_sat_div (.aclk(aclk), .en(en), .num(snum), .den(sden), .quo(sq));

    // Side pipeline matching the divider latency.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[Q-2:0], take};
        end
        if (en) begin
            grey_reg <= {grey_reg[Q-2:0], in_item.grey};
            lvl_reg[0] <= in_item.level;
            for (int i = 1; i < Q; i++) begin
                lvl_reg[i] <= lvl_reg[i-1];
            end
        end
    end

    // Output register with saturation clamp.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= v_reg[Q-1];
        end
        if (en) begin
            hue_reg <= grey_reg[Q-1] ? '0 : hq[rhh_pkg::HueW-1:0];
            if (grey_reg[Q-1]) begin
                sat_reg <= '0;
            end else if (sq[Q-1]) begin
                sat_reg <= '1;
            end else begin
                sat_reg <= sq[rhh_pkg::SatW-1:0];
            end
            lev_reg <= lvl_reg[Q-1];
        end
    end

    assign out_valid  = ov_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign level      = lev_reg;

endmodule

FILE: hw/rtl/rgb_to_hsv_hsl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV/HSL converter
// Converts 8-bit RGB pixels to hue plus HSV or HSL saturation and level.
// ----------------------------------------------------------------------------
// Path from input request to output valid: front register, queue,
// 17 divider stages of one quotient bit, output register.
// Throughput: one request per cycle when m_tready does not stall; the divider pipelines set that figure.
// Reset: synchronous active-low aresetn empties all stages and sets HSV mode.
module rgb_to_hsv_hsl (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // output_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // hue[10:0], saturation[26:11], level[35:27], 0
);

    logic           mode_reg;
    logic           f_valid;
    logic           q_not_full;
    logic           q_not_empty;
    logic           b_ready;
    rhh_pkg::item_t f_item;
    rhh_pkg::item_t q_item;
    logic [rhh_pkg::HueW-1:0]   hue;
    logic [rhh_pkg::SatW-1:0]   sat;
    logic [rhh_pkg::LevelW-1:0] lvl;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rhh_pkg::ModeHsv;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    rhh_front u_front (
        .aclk(aclk), .aresetn(aresetn), .mode(mode_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .red(s_tdata[7:0]), .green(s_tdata[15:8]), .blue(s_tdata[23:16]),
        .out_valid(f_valid), .out_ready(q_not_full), .out_item(f_item)
    );

    rhh_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(f_valid && q_not_full), .push_item(f_item), .not_full(q_not_full),
        .pop(q_not_empty && b_ready), .not_empty(q_not_empty), .pop_item(q_item)
    );

    rhh_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_not_empty), .in_ready(b_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .hue(hue), .saturation(sat), .level(lvl)
    );

    assign m_tdata = {4'd0, lvl, sat, hue};

endmodule

FILE: hw/rtl/rgb_to_hsv_hsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV/HSL port checker
// Port-level assertions on output stall stability, reset and result accounting.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata
);

    logic [5:0] pend_reg;

    // Count of accepted requests whose results are not yet delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 6'(s_tvalid && s_tready) - 6'(m_tvalid && m_tready);
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 6'd0)
        else $error("result without a pending request");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 6'd24)
        else $error("more requests in flight than the pipeline holds");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:36] == 4'd0 && m_tdata[35:27] <= 9'd510)
        else $error("output padding or level out of range");

endmodule

bind rgb_to_hsv_hsl rgb_to_hsv_hsl_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
